FILE: sv/csv_field_tokenizer_assert.svh
// Assertion macros used by the tokenizer module.
`ifndef CSV_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CSVT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("csv tokenizer assertion failed");
`define CSVT_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("csv tokenizer forbidden condition");
`else
`define CSVT_ASSERT(label, clk, rst_n, prop)
`define CSVT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: sv/csvt_pkg.sv
package csvt_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ColW = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DefaultMaxColumns = 256;

  localparam logic [ByteW-1:0] CharNewline = 8'd10;
  localparam logic [ByteW-1:0] CharComma = 8'd44;
  localparam logic [ByteW-1:0] CharQuote = 8'd34;

  localparam logic [CfgIdxW-1:0] RegDelimiter = 2'd0;
  localparam logic [CfgIdxW-1:0] RegQuote = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHeaderMode = 2'd2;

  typedef enum logic [1:0] {
    MODE_UNQ,
    MODE_QUO,
    MODE_AFT
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0,
    ERR_STRAY_QUOTE = 3'd1,
    ERR_JUNK_AFTER_QUOTE = 3'd2,
    ERR_WIDTH_MISMATCH = 3'd3,
    ERR_BAD_CONFIG = 3'd4,
    ERR_TOO_MANY_COLUMNS = 3'd5
  } err_e;

  typedef struct packed {
    logic [ByteW-1:0] delimiter_char;
    logic [ByteW-1:0] quote_char;
  } cfg_t;

  typedef struct packed {
    mode_e mode;
    logic  value_empty;
    logic  width_known;
    logic  in_header_line;
    err_e  sticky_error;
  } state_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_content;
    logic             field_done;
    logic             row_done;
    logic             is_header;
    logic [ColW-1:0]  column_index;
    err_e             error_code;
  } res_t;

endpackage

FILE: sv/csv_field_tokenizer.sv
// CSV field tokenizer: one text byte per transfer in, one result per byte out.
// A byte is taken in every cycle unless a result waits for m_axis_tready. Each
// byte passes an input register and a result register, and its result is offered
// on the master side from the result register. While a result waits for
// m_axis_tready, the next byte is held in the input register and no further byte is taken.
// The figure of one byte per cycle is set by the parser state update (mode,
// field count, row width, error), which is combinational. There is no start-up
// pass after reset. Configuration must be written by the user only while idle;
// the block does not enforce it. header_mode acts only before the first byte.
`include "csv_field_tokenizer_assert.svh"

module csv_field_tokenizer #(
  parameter int unsigned MAX_COLUMNS = csvt_pkg::DefaultMaxColumns
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csvt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [csvt_pkg::ByteW-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] in_byte
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] data_byte, [16:8] column_index, [19:17] error_code, [23:20] zero
  output logic [23:0]                    m_axis_tdata,
  // [0] is_content, [1] field_done, [2] is_header
  output logic [2:0]                     m_axis_tuser,
  output logic                           m_axis_tlast   // row_done
);

  localparam int unsigned CntW = $clog2(MAX_COLUMNS + 1);

  csvt_pkg::cfg_t              cfg_q;
  csvt_pkg::state_t            state_q;
  csvt_pkg::state_t            state_d;
  logic [CntW-1:0]             fc_q;
  logic [CntW-1:0]             fc_d;
  logic [CntW-1:0]             rw_q;
  logic [CntW-1:0]             rw_d;
  logic                        started_q;
  logic                        in_valid_q;
  logic                        in_valid_d;
  logic [csvt_pkg::ByteW-1:0]  in_byte_q;
  logic                        out_valid_q;
  logic                        out_valid_d;
  csvt_pkg::res_t              res_q;
  csvt_pkg::res_t              step_res;
  logic                        s_accept;
  logic                        advance;

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign in_valid_d = s_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready);

  csvt_step #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_step (
    .cfg_i        (cfg_q),
    .byte_i       (in_byte_q),
    .state_i      (state_q),
    .field_count_i(fc_q),
    .row_width_i  (rw_q),
    .state_o      (state_d),
    .field_count_o(fc_d),
    .row_width_o  (rw_d),
    .res_o        (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter_char <= csvt_pkg::CharComma;
      cfg_q.quote_char <= csvt_pkg::CharQuote;
      state_q.mode <= csvt_pkg::MODE_UNQ;
      state_q.value_empty <= 1'b1;
      state_q.width_known <= 1'b0;
      state_q.in_header_line <= 1'b0;
      state_q.sticky_error <= csvt_pkg::ERR_NONE;
      fc_q <= '0;
      rw_q <= '0;
      started_q <= 1'b0;
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (s_accept) begin
        started_q <= 1'b1;
      end
      if (advance) begin
        state_q <= state_d;
        fc_q <= fc_d;
        rw_q <= rw_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          csvt_pkg::RegDelimiter: cfg_q.delimiter_char <= cfg_data_i;
          csvt_pkg::RegQuote: cfg_q.quote_char <= cfg_data_i;
          csvt_pkg::RegHeaderMode: begin
            if (!started_q) begin
              state_q.in_header_line <= cfg_data_i[0];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {4'b0000, res_q.error_code, res_q.column_index, res_q.data_byte};
  assign m_axis_tuser = {res_q.is_header, res_q.field_done, res_q.is_content};
  assign m_axis_tlast = res_q.row_done;

  `CSVT_ASSERT(a_error_sticky, clk_i, rst_ni,
    (state_q.sticky_error != csvt_pkg::ERR_NONE) |=>
    (state_q.sticky_error == $past(state_q.sticky_error)))
  `CSVT_ASSERT(a_width_sticky, clk_i, rst_ni, state_q.width_known |=> state_q.width_known)
  `CSVT_ASSERT(a_row_clears_count, clk_i, rst_ni, (advance && step_res.row_done) |=> (fc_q == '0))
  `CSVT_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, fc_q > CntW'(MAX_COLUMNS))
  `CSVT_ASSERT_NEVER(a_error_no_flags, clk_i, rst_ni,
    out_valid_q && (res_q.error_code != csvt_pkg::ERR_NONE) &&
    (res_q.is_content || res_q.field_done || res_q.row_done))

endmodule

FILE: sv/csvt_step.sv
module csvt_step #(
  parameter int unsigned MAX_COLUMNS = csvt_pkg::DefaultMaxColumns,
  localparam int unsigned CntW = $clog2(MAX_COLUMNS + 1)
) (
  input  csvt_pkg::cfg_t               cfg_i,
  input  logic [csvt_pkg::ByteW-1:0]   byte_i,
  input  csvt_pkg::state_t             state_i,
  input  logic [CntW-1:0]              field_count_i,
  input  logic [CntW-1:0]              row_width_i,
  output csvt_pkg::state_t             state_o,
  output logic [CntW-1:0]              field_count_o,
  output logic [CntW-1:0]              row_width_o,
  output csvt_pkg::res_t               res_o
);

  logic            bad_cfg;
  logic            overflow;
  logic [CntW-1:0] fc_inc;
  logic            content;
  logic            fdone;
  logic            rdone;

  assign overflow = (field_count_i >= CntW'(MAX_COLUMNS));
  assign fc_inc = field_count_i + CntW'(1);
  assign bad_cfg = (cfg_i.delimiter_char == cfg_i.quote_char) ||
                   (!state_i.width_known && !state_i.in_header_line &&
                    ((cfg_i.delimiter_char == csvt_pkg::CharNewline) ||
                     (cfg_i.quote_char == csvt_pkg::CharNewline)));

  always_comb begin
    state_o = state_i;
    field_count_o = field_count_i;
    row_width_o = row_width_i;
    content = 1'b0;
    fdone = 1'b0;
    rdone = 1'b0;
    if (state_i.sticky_error != csvt_pkg::ERR_NONE) begin
      state_o = state_i;
    end else if (bad_cfg) begin
      state_o.sticky_error = csvt_pkg::ERR_BAD_CONFIG;
    end else if (state_i.in_header_line) begin
      if (byte_i == csvt_pkg::CharNewline) begin
        if (!state_i.value_empty && overflow) begin
          state_o.sticky_error = csvt_pkg::ERR_TOO_MANY_COLUMNS;
        end else begin
          fdone = !state_i.value_empty;
          rdone = 1'b1;
          state_o.width_known = 1'b1;
          row_width_o = state_i.value_empty ? field_count_i : fc_inc;
          field_count_o = '0;
          state_o.value_empty = 1'b1;
          state_o.in_header_line = 1'b0;
        end
      end else if (byte_i == cfg_i.delimiter_char) begin
        if (overflow) begin
          state_o.sticky_error = csvt_pkg::ERR_TOO_MANY_COLUMNS;
        end else begin
          fdone = 1'b1;
          field_count_o = fc_inc;
          state_o.value_empty = 1'b1;
        end
      end else begin
        content = 1'b1;
        state_o.value_empty = 1'b0;
      end
    end else if (byte_i == cfg_i.delimiter_char) begin
      if (state_i.mode == csvt_pkg::MODE_QUO) begin
        content = 1'b1;
        state_o.value_empty = 1'b0;
      end else if (overflow) begin
        state_o.sticky_error = csvt_pkg::ERR_TOO_MANY_COLUMNS;
      end else begin
        fdone = 1'b1;
        state_o.value_empty = 1'b1;
        state_o.mode = csvt_pkg::MODE_UNQ;
        if (state_i.width_known && (fc_inc == row_width_i)) begin
          rdone = 1'b1;
          field_count_o = '0;
        end else begin
          field_count_o = fc_inc;
        end
      end
    end else if (byte_i == cfg_i.quote_char) begin
      case (state_i.mode)
        csvt_pkg::MODE_UNQ: begin
          if (state_i.value_empty) begin
            state_o.mode = csvt_pkg::MODE_QUO;
          end else begin
            state_o.sticky_error = csvt_pkg::ERR_STRAY_QUOTE;
          end
        end
        csvt_pkg::MODE_QUO: begin
          state_o.mode = csvt_pkg::MODE_AFT;
        end
        default: begin
          // A doubled quote: one literal quote, back inside the quoted value.
          content = 1'b1;
          state_o.value_empty = 1'b0;
          state_o.mode = csvt_pkg::MODE_QUO;
        end
      endcase
    end else if (state_i.mode == csvt_pkg::MODE_QUO) begin
      content = 1'b1;
      state_o.value_empty = 1'b0;
    end else if (byte_i == csvt_pkg::CharNewline) begin
      if (overflow) begin
        state_o.sticky_error = csvt_pkg::ERR_TOO_MANY_COLUMNS;
      end else if (state_i.width_known && (fc_inc != row_width_i)) begin
        state_o.sticky_error = csvt_pkg::ERR_WIDTH_MISMATCH;
        field_count_o = fc_inc;
        state_o.value_empty = 1'b1;
      end else begin
        fdone = 1'b1;
        rdone = 1'b1;
        field_count_o = '0;
        state_o.value_empty = 1'b1;
        state_o.mode = csvt_pkg::MODE_UNQ;
        if (!state_i.width_known) begin
          state_o.width_known = 1'b1;
          row_width_o = fc_inc;
        end
      end
    end else if (state_i.mode == csvt_pkg::MODE_UNQ) begin
      content = 1'b1;
      state_o.value_empty = 1'b0;
    end else begin
      state_o.sticky_error = csvt_pkg::ERR_JUNK_AFTER_QUOTE;
    end
  end

  always_comb begin
    res_o.error_code = state_o.sticky_error;
    if (state_o.sticky_error != csvt_pkg::ERR_NONE) begin
      res_o.data_byte = '0;
      res_o.is_content = 1'b0;
      res_o.field_done = 1'b0;
      res_o.row_done = 1'b0;
      res_o.is_header = state_o.in_header_line;
      res_o.column_index = csvt_pkg::ColW'(field_count_o);
    end else begin
      res_o.data_byte = content ? byte_i : '0;
      res_o.is_content = content;
      res_o.field_done = fdone;
      res_o.row_done = rdone;
      res_o.is_header = state_i.in_header_line;
      res_o.column_index = csvt_pkg::ColW'(field_count_i);
    end
  end

endmodule
